// ===== rtl/core/tpcs_pkg.sv =====
// shared types, constants and prescaler tables for the timer prescaler search
`timescale 1ns / 1ps

package tpcs_pkg;

    // fixed point and timer widths
    localparam int FREQ_FRAC_BITS      = 8;
    localparam int WIDE_COMPARE_BITS   = 16;
    localparam int NARROW_COMPARE_BITS = 8;
    localparam int CLOCK_W             = 32;
    localparam int TARGET_W            = 32;
    localparam int MIN_SHIFT           = 2;

    localparam logic [CLOCK_W-1:0] CLOCK_RESET = 32'd16000000;

    // shifted clock, numerator and divider widths
    localparam int S_W        = CLOCK_W - MIN_SHIFT;
    localparam int NUM_W      = S_W + FREQ_FRAC_BITS;
    localparam int DIVIDEND_W = ((NUM_W + 1 > TARGET_W) ? NUM_W + 1 : TARGET_W) + 1;
    localparam int DIVISOR_W  = TARGET_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    // timer choice codes
    localparam logic [1:0] CMD_T0 = 2'd0;
    localparam logic [1:0] CMD_T1 = 2'd1;
    localparam logic [1:0] CMD_T2 = 2'd2;

    // request and result items
    typedef struct packed {
        logic [1:0]          command;
        logic [TARGET_W-1:0] target_frequency;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  clock_select;
        logic [15:0] compare_value;
        logic        found;
    } out_item_t;

    // divider control and status
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    // number of prescalers of a timer, 0 for an unknown code
    function automatic logic [2:0] table_len(input logic [1:0] cmd);
        logic [2:0] len;
        case (cmd)
            CMD_T0:  len = 3'd5;
            CMD_T1:  len = 3'd5;
            CMD_T2:  len = 3'd7;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    // prescaler shift of a timer's table entry
    function automatic logic [3:0] prescale_shift(input logic [1:0] cmd, input logic [2:0] idx);
        logic [3:0] sh;
        if (cmd == CMD_T2)
        begin
            case (idx)
                3'd0:    sh = 4'd2;
                3'd1:    sh = 4'd4;
                3'd2:    sh = 4'd6;
                3'd3:    sh = 4'd7;
                3'd4:    sh = 4'd8;
                3'd5:    sh = 4'd9;
                default: sh = 4'd11;
            endcase
        end
        else
        begin
            case (idx)
                3'd0:    sh = 4'd2;
                3'd1:    sh = 4'd4;
                3'd2:    sh = 4'd7;
                3'd3:    sh = 4'd9;
                default: sh = 4'd11;
            endcase
        end
        return sh;
    endfunction

endpackage

// ===== rtl/core/tpcs_div.sv =====
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module tpcs_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tpcs_pkg::div_req_t req,
    output tpcs_pkg::div_rsp_t rsp
);
    import tpcs_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    // one restoring step: bring down the next dividend bit and try a subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIVIDEND_W - 1);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (diff[DIVISOR_W])
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/core/timer_prescaler_compare_search.sv =====
// top level: prescaler and compare value search sequencer
`timescale 1ns / 1ps

// Finds the timer prescaler and compare value that come closest to a wanted
// frequency. cfg_wr_en/cfg_wr_data write the cpu clock in hertz (reset value
// 16000000); write it only while the block is idle.
// Request channel req_valid/req_ready/req_data carries the timer choice and
// the target frequency (unsigned Q24.8). Result channel res_valid/res_ready/
// res_data returns clock_select, compare_value and found, one item per request.
// Each prescaler of the chosen table is tried in turn on one shared serial
// divider, one quotient bit per cycle: first a division for the compare
// value, then one for the resulting frequency when the compare value fits
// the timer. A zero target or unknown timer code skips the search and gives
// a result with found low. req_ready is high only while no search runs,
// and rises together with res_valid when the result is loaded.
// The result sits in an output register; a new request is taken while it
// waits, and a search that ends while res_ready is low holds until the
// register frees. Reset clears res_valid and restores the clock register.

module timer_prescaler_compare_search (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  logic               req_valid,
    output logic               req_ready,
    input  tpcs_pkg::in_item_t req_data,
    output logic               res_valid,
    input  logic               res_ready,
    output tpcs_pkg::out_item_t res_data
);
    import tpcs_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_CMP_GO   = 6'b000010,
        ST_CMP_WAIT = 6'b000100,
        ST_FRQ_GO   = 6'b001000,
        ST_FRQ_WAIT = 6'b010000,
        ST_FINISH   = 6'b100000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CLOCK_W-1:0]       clock_reg, clock_next;
    logic                     have_reg, have_next;
    logic                     res_valid_reg, res_valid_next;
    logic [1:0]               cmd_reg, cmd_next;
    logic [TARGET_W-1:0]      tgt_reg, tgt_next;
    logic [2:0]               idx_reg, idx_next;
    logic [WIDE_COMPARE_BITS-1:0] cmp_reg, cmp_next;
    logic [DIVIDEND_W-1:0]    best_err_reg, best_err_next;
    logic [15:0]              best_cmp_reg, best_cmp_next;
    logic [2:0]               best_idx_reg, best_idx_next;
    out_item_t                res_data_reg, res_data_next;

    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    logic [CLOCK_W-1:0]       clk_shifted;
    logic [S_W-1:0]           s_val;
    logic [DIVIDEND_W-1:0]    quot;
    logic                     cmp_fits;
    logic [DIVIDEND_W-1:0]    tgt_ext;
    logic [DIVIDEND_W-1:0]    err;
    logic                     last_cand;

    // shared divider
    tpcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // shifted clock of the current prescaler
    always_comb
    begin
        clk_shifted = clock_reg >> prescale_shift(cmd_reg, idx_reg);
        s_val       = clk_shifted[S_W-1:0];
    end

    // divider operands: rounded compare value, then the frequency it gives
    always_comb
    begin
        div_req.start = (state_reg == ST_CMP_GO) || (state_reg == ST_FRQ_GO);
        if (state_reg == ST_FRQ_GO)
        begin
            div_req.dividend = DIVIDEND_W'(s_val) << FREQ_FRAC_BITS;
            div_req.divisor  = DIVISOR_W'(cmp_reg);
        end
        else
        begin
            div_req.dividend = (DIVIDEND_W'(s_val) << (FREQ_FRAC_BITS + 1))
                             + DIVIDEND_W'(tgt_reg);
            div_req.divisor  = {tgt_reg, 1'b0};
        end
    end

    // candidate checks and error
    always_comb
    begin
        quot = div_rsp.quotient;
        if (cmd_reg == CMD_T1)
            cmp_fits = ((quot >> WIDE_COMPARE_BITS) == '0) && (quot != '0);
        else
            cmp_fits = ((quot >> NARROW_COMPARE_BITS) == '0) && (quot != '0);
        tgt_ext   = DIVIDEND_W'(tgt_reg);
        err       = (tgt_ext > quot) ? (tgt_ext - quot) : (quot - tgt_ext);
        last_cand = (idx_reg == 3'(table_len(cmd_reg) - 3'd1));
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clock_next     = clock_reg;
        have_next      = have_reg;
        res_valid_next = res_valid_reg;
        cmd_next       = cmd_reg;
        tgt_next       = tgt_reg;
        idx_next       = idx_reg;
        cmp_next       = cmp_reg;
        best_err_next  = best_err_reg;
        best_cmp_next  = best_cmp_reg;
        best_idx_next  = best_idx_reg;
        res_data_next  = res_data_reg;

        if (cfg_wr_en)
            clock_next = cfg_wr_data;

        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next  = req_data.command;
                    tgt_next  = req_data.target_frequency;
                    idx_next  = '0;
                    have_next = 1'b0;
                    if ((req_data.target_frequency == '0)
                        || (table_len(req_data.command) == 3'd0))
                        state_next = ST_FINISH;
                    else
                        state_next = ST_CMP_GO;
                end
            end
            ST_CMP_GO:
            begin
                state_next = ST_CMP_WAIT;
            end
            ST_CMP_WAIT:
            begin
                if (div_rsp.done)
                begin
                    cmp_next = quot[WIDE_COMPARE_BITS-1:0];
                    if (cmp_fits)
                        state_next = ST_FRQ_GO;
                    else if (last_cand)
                        state_next = ST_FINISH;
                    else
                    begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = ST_CMP_GO;
                    end
                end
            end
            ST_FRQ_GO:
            begin
                state_next = ST_FRQ_WAIT;
            end
            ST_FRQ_WAIT:
            begin
                if (div_rsp.done)
                begin
                    // keep the first candidate with strictly least error
                    if (!have_reg || (err < best_err_reg))
                    begin
                        have_next     = 1'b1;
                        best_err_next = err;
                        best_cmp_next = 16'(cmp_reg);
                        best_idx_next = idx_reg;
                    end
                    if (last_cand)
                        state_next = ST_FINISH;
                    else
                    begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = ST_CMP_GO;
                    end
                end
            end
            ST_FINISH:
            begin
                // load the output register once it is free
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    if (have_reg)
                    begin
                        res_data_next.clock_select  = best_idx_reg + 3'd1;
                        res_data_next.compare_value = best_cmp_reg;
                        res_data_next.found         = 1'b1;
                    end
                    else
                    begin
                        res_data_next.clock_select  = '0;
                        res_data_next.compare_value = '0;
                        res_data_next.found         = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clock_reg     <= CLOCK_RESET;
            have_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clock_reg     <= clock_next;
            have_reg      <= have_next;
            res_valid_reg <= res_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        tgt_reg      <= tgt_next;
        cmp_reg      <= cmp_next;
        best_err_reg <= best_err_next;
        best_cmp_reg <= best_cmp_next;
        best_idx_reg <= best_idx_next;
        res_data_reg <= res_data_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// ===== verif/timer_prescaler_compare_search_tb.sv =====
// testbench for the timer prescaler and compare value search block
`timescale 1ns / 1ps

module timer_prescaler_compare_search_tb;

    import tpcs_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 6;
    localparam int LONG_HOLD     = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SEARCH_CYCLES = 700;
    localparam int QUIET_LIMIT   = 20000;
    localparam int OPENING_N     = 21;
    localparam int FIRST_ITEMS   = 160;
    localparam int PHASE_ITEMS   = 125;
    localparam int CLOCK_PHASES  = 6;

    localparam logic [1:0]      CMD_UNUSED   = 2'd3;
    localparam logic [4:0][3:0] FIVE_SHIFTS  = {4'd11, 4'd9, 4'd7, 4'd4, 4'd2};
    localparam logic [6:0][3:0] SEVEN_SHIFTS = {4'd11, 4'd9, 4'd8, 4'd7, 4'd6, 4'd4, 4'd2};
    localparam out_item_t       NO_FIT       = '0;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] target;
        logic        pinned;
        out_item_t   pinned_res;
    } opening_row_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        req_valid   = 1'b0;
    logic        req_ready;
    in_item_t    req_data    = '0;
    logic        res_valid;
    logic        res_ready   = 1'b0;
    out_item_t   res_data;

    // typed-in result that travels alongside a request item
    logic        pin_valid = 1'b0;
    out_item_t   pin_res   = '0;

    logic [31:0] model_clock_hz = CLOCK_RESET;
    out_item_t   expected_picks [$];
    bit          hold_request    = 1'b0;
    int          requests_taken  = 0;
    int          results_checked = 0;
    int          results_found   = 0;
    int          clock_writes    = 0;
    int          mismatches      = 0;

    // opening rows, all run at the reset clock of 16 MHz
    opening_row_t opening_rows [0:OPENING_N-1] = '{
        '{CMD_T0,     32'd0,          1'b1, NO_FIT},
        '{CMD_T1,     32'd0,          1'b1, NO_FIT},
        '{CMD_T2,     32'd0,          1'b1, NO_FIT},
        '{CMD_UNUSED, 32'd0,          1'b1, NO_FIT},
        '{CMD_UNUSED, 32'd256000,     1'b1, NO_FIT},
        '{CMD_UNUSED, 32'hFFFF_FFFF,  1'b1, NO_FIT},
        '{CMD_T0,     32'hFFFF_FFFF,  1'b1, NO_FIT},
        '{CMD_T1,     32'hFFFF_FFFF,  1'b1, NO_FIT},
        '{CMD_T2,     32'hFFFF_FFFF,  1'b1, NO_FIT},
        '{CMD_T0,     32'd1,          1'b1, NO_FIT},
        '{CMD_T1,     32'd1,          1'b1, NO_FIT},
        '{CMD_T2,     32'd1,          1'b1, NO_FIT},
        '{CMD_T0,     32'd256000,     1'b0, NO_FIT},
        '{CMD_T1,     32'd256,        1'b0, NO_FIT},
        '{CMD_T2,     32'd9728000,    1'b0, NO_FIT},
        '{CMD_T1,     32'd12800,      1'b0, NO_FIT},
        '{CMD_T0,     32'd4096000,    1'b0, NO_FIT},
        '{CMD_T2,     32'h0000_0080,  1'b0, NO_FIT},
        '{CMD_T0,     32'h00FF_FFFF,  1'b0, NO_FIT},
        '{CMD_T1,     32'h8000_0000,  1'b0, NO_FIT},
        '{CMD_T2,     32'd256000,     1'b0, NO_FIT}
    };

    timer_prescaler_compare_search uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_data    (req_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // prescaler choice with least frequency error, first one wins a tie
    function automatic out_item_t best_prescaler(input logic [1:0] cmd,
                                                 input logic [31:0] target,
                                                 input logic [31:0] clock_hz);
        logic [63:0] tgt, numer, cmpv, freq, err, best_err, best_cmp, ceiling;
        logic [3:0]  sh;
        int          n_shifts, best_i;
        bit          have;
        out_item_t   pick;
        tgt      = 64'(target);
        have     = 1'b0;
        best_err = '0;
        best_cmp = '0;
        best_i   = 0;
        case (cmd)
            CMD_T0:  begin n_shifts = 5; ceiling = 64'd255; end
            CMD_T1:  begin n_shifts = 5; ceiling = (64'd1 << WIDE_COMPARE_BITS) - 64'd1; end
            CMD_T2:  begin n_shifts = 7; ceiling = 64'd255; end
            default: begin n_shifts = 0; ceiling = 64'd0; end
        endcase
        if (tgt != 0)
        begin
            for (int i = 0; i < n_shifts; i++)
            begin
                sh    = (cmd == CMD_T2) ? SEVEN_SHIFTS[i] : FIVE_SHIFTS[i];
                numer = (64'(clock_hz) >> sh) << FREQ_FRAC_BITS;
                cmpv  = (64'd2 * numer + tgt) / (64'd2 * tgt);
                // zero or too wide for the timer: skip this prescaler
                if (cmpv != 0 && cmpv <= ceiling)
                begin
                    freq = numer / cmpv;
                    err  = (tgt > freq) ? (tgt - freq) : (freq - tgt);
                    if (!have || err < best_err)
                    begin
                        have     = 1'b1;
                        best_err = err;
                        best_cmp = cmpv;
                        best_i   = i;
                    end
                end
            end
        end
        pick = NO_FIT;
        if (have)
        begin
            pick.clock_select  = 3'(best_i + 1);
            pick.compare_value = best_cmp[15:0];
            pick.found         = 1'b1;
        end
        return pick;
    endfunction

    // target near what some prescaler and compare value can reach, or noise
    function automatic logic [31:0] pick_target(input logic [1:0] cmd,
                                                input logic [31:0] clock_hz);
        logic [63:0] base;
        logic [31:0] target;
        logic [3:0]  sh;
        logic [16:0] cmpv;
        int          idx;
        case ($urandom_range(0, 15))
            0:       target = '0;
            1, 2, 3: target = $urandom;
            4, 5:    target = $urandom_range(1, 1000);
            default:
            begin
                idx  = (cmd == CMD_T2) ? $urandom_range(0, 6) : $urandom_range(0, 4);
                sh   = (cmd == CMD_T2) ? SEVEN_SHIFTS[idx] : FIVE_SHIFTS[idx];
                cmpv = (cmd == CMD_T1) ? $urandom_range(1, 70000) : $urandom_range(1, 270);
                base = ((64'(clock_hz) >> sh) << FREQ_FRAC_BITS) / cmpv;
                case ($urandom_range(0, 2))
                    0:       base = base + (base >> $urandom_range(2, 12));
                    1:       base = base - (base >> $urandom_range(2, 12));
                    default: base = base ^ 64'($urandom_range(0, 3));
                endcase
                if (base == 0)
                    target = 32'd1;
                else if (base > 64'hFFFF_FFFF)
                    target = 32'hFFFF_FFFF;
                else
                    target = base[31:0];
            end
        endcase
        return target;
    endfunction

    // offer one request item and hold it until it is taken
    task automatic offer_request(input in_item_t item, input logic pinned,
                                 input out_item_t pinned_res);
        req_data  <= item;
        pin_valid <= pinned;
        pin_res   <= pinned_res;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle_idle();
        req_valid <= 1'b0;
        while (expected_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_clock(input logic [31:0] hz);
        cfg_wr_data <= hz;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        model_clock_hz  = hz;
        clock_writes++;
    endtask

    // random requests in bursts with random gaps
    task automatic request_stream(input int count, input int hold_at, input int pause_at);
        in_item_t item;
        int       burst_left, gap;
        burst_left = 0;
        for (int k = 0; k < count; k++)
        begin
            if (k == pause_at)
                settle_idle();
            if (k == hold_at)
            begin
                // receiver goes quiet while a gapless burst fills the block
                hold_request = 1'b1;
                burst_left   = 10;
            end
            else if (burst_left == 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: gap = 0;
                    9:             gap = $urandom_range(50, 200);
                    default:       gap = $urandom_range(1, 20);
                endcase
                if (gap > 0)
                begin
                    req_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 12);
            end
            case ($urandom_range(0, 15))
                0:                item.command = CMD_UNUSED;
                1, 2, 3, 4, 5:    item.command = CMD_T0;
                6, 7, 8, 9, 10:   item.command = CMD_T1;
                default:          item.command = CMD_T2;
            endcase
            item.target_frequency = pick_target(item.command, model_clock_hz);
            offer_request(item, 1'b0, NO_FIT);
            burst_left--;
        end
    endtask

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int run_left, stall_left;
        run_left   = 0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                res_ready <= 1'b0;
                stall_left--;
            end
            else if (run_left > 0)
            begin
                res_ready <= 1'b1;
                run_left--;
            end
            else
            begin
                res_ready <= 1'b1;
                run_left   = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(0, 30);
                case ($urandom_range(0, 7))
                    0, 1, 2, 3: stall_left = 0;
                    4, 5:       stall_left = $urandom_range(1, 4);
                    6:          stall_left = $urandom_range(5, 40);
                    default:    stall_left = $urandom_range(100, 400);
                endcase
            end
        end
    end

    // predict on each taken request, check each taken result
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                requests_taken++;
                if (pin_valid)
                    expected_picks.push_back(pin_res);
                else
                    expected_picks.push_back(best_prescaler(req_data.command,
                                                            req_data.target_frequency,
                                                            model_clock_hz));
            end
            if (res_valid && res_ready)
            begin
                if (expected_picks.size() == 0)
                begin
                    $display("%0t: unexpected result item %h", $time, res_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_picks.pop_front();
                    results_checked++;
                    if (res_data.found === 1'b1)
                        results_found++;
                    if (res_data.clock_select !== want.clock_select)
                    begin
                        $display("%0t: clock_select expected %0d, got %0d", $time,
                                 want.clock_select, res_data.clock_select);
                        mismatches++;
                    end
                    if (res_data.compare_value !== want.compare_value)
                    begin
                        $display("%0t: compare_value expected %0d, got %0d", $time,
                                 want.compare_value, res_data.compare_value);
                        mismatches++;
                    end
                    if (res_data.found !== want.found)
                    begin
                        $display("%0t: found expected %0d, got %0d", $time,
                                 want.found, res_data.found);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // main sequence
    initial
    begin
        in_item_t    item;
        logic [31:0] new_clock;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening rows at the reset clock
        for (int r = 0; r < OPENING_N; r++)
        begin
            item.command          = opening_rows[r].command;
            item.target_frequency = opening_rows[r].target;
            offer_request(item, opening_rows[r].pinned, opening_rows[r].pinned_res);
        end
        request_stream(FIRST_ITEMS, 40, 100);
        settle_idle();

        // clock settings including both extremes and zero
        for (int p = 0; p < CLOCK_PHASES; p++)
        begin
            case (p)
                0:       new_clock = 32'hFFFF_FFFF;
                1:       new_clock = 32'd1;
                2:       new_clock = 32'd0;
                3:       new_clock = 32'd8000000;
                4:       new_clock = $urandom_range(1000000, 200000000);
                default: new_clock = 32'd20000000;
            endcase
            write_clock(new_clock);
            request_stream(PHASE_ITEMS, -1, 60);
            settle_idle();
        end

        repeat (SEARCH_CYCLES) @(posedge clk);
        $display("covered %0d requests over %0d clock settings, %0d checked results",
                 requests_taken, clock_writes + 1, results_checked);
        $display("%0d results found a prescaler, %0d field mismatches",
                 results_found, mismatches);
        if (mismatches == 0 && expected_picks.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/tpcs_pkg.sv
rtl/core/tpcs_div.sv
rtl/core/timer_prescaler_compare_search.sv
verif/timer_prescaler_compare_search_tb.sv
